### src/ivcf_pkg.sv
// Package for the interleaved video cell fetch.
// Field widths, layout constants, register codes and shared types.
// No dependencies.
package ivcf_pkg;

   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int COLUMN_W = 6;
   localparam int LINE_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int PIXELS = 8;

   localparam int DEF_BYTE_COLUMNS = 40;
   localparam int DEF_SCAN_LINES = 256;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXTENDED_LAYOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_PLANE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_OFFSET = 2'd2;

   localparam logic [BYTE_W-1:0] BG_OFFSET_RESET = 8'd16;

   localparam logic [ADDR_W-1:0] LEFT_COLOUR_BASE = 16'h2800;
   localparam logic [ADDR_W-1:0] RIGHT_PIXEL_BASE = 16'h2000;
   localparam logic [ADDR_W-1:0] RIGHT_COLOUR_OFFSET = 16'h0800;
   localparam logic [ADDR_W-1:0] BANK_SIZE = 16'd16384;

   localparam logic [BYTE_W-1:0] BG_MASK = 8'h07;
   localparam logic [BYTE_W-1:0] BLINK_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] FG_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] COLUMN_MASK = 8'h3F;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type [PIXELS-1:0] pixel_row_type;

   typedef struct packed {
      addr_type pixel;
      addr_type colour;
   } fetch_addr_type;

endpackage

### src/ivcf_req_if.sv
// Request channel of the video cell fetch: valid, ready and one input word.
// Depends on ivcf_pkg.
interface ivcf_req_if;
   import ivcf_pkg::*;

   logic valid;
   logic ready;
   logic mode;
   logic [ADDR_W-1:0] write_address;
   logic [BYTE_W-1:0] write_data;
   logic [COLUMN_W-1:0] column;
   logic [LINE_W-1:0] scan_line;
   logic blink_active;

   modport source (
      output valid, mode, write_address, write_data, column, scan_line, blink_active,
      input ready
   );
   modport sink (
      input valid, mode, write_address, write_data, column, scan_line, blink_active,
      output ready
   );
endinterface

### src/ivcf_rsp_if.sv
// Response channel of the video cell fetch: valid, ready and eight palette indices.
// Depends on ivcf_pkg.
interface ivcf_rsp_if;
   import ivcf_pkg::*;

   logic valid;
   logic ready;
   logic [BYTE_W-1:0] pixel_0;
   logic [BYTE_W-1:0] pixel_1;
   logic [BYTE_W-1:0] pixel_2;
   logic [BYTE_W-1:0] pixel_3;
   logic [BYTE_W-1:0] pixel_4;
   logic [BYTE_W-1:0] pixel_5;
   logic [BYTE_W-1:0] pixel_6;
   logic [BYTE_W-1:0] pixel_7;

   modport source (
      output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7,
      input ready
   );
   modport sink (
      input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6, pixel_7,
      output ready
   );
endinterface

### src/ivcf_addr.sv
// Address former: pixel and colour byte addresses for one cell.
// Standard interleaved layout or dual-plane column layout. Depends on ivcf_pkg.
module ivcf_addr (
   input  logic                         extended_layout,
   input  logic                         display_plane,
   input  logic [ivcf_pkg::COLUMN_W-1:0] column,
   input  logic [ivcf_pkg::LINE_W-1:0]   scan_line,
   output ivcf_pkg::fetch_addr_type      addr
);
   import ivcf_pkg::*;

   logic [COLUMN_W-1:0] c;
   logic [LINE_W-1:0] y;

   assign c = column;
   assign y = scan_line;

   always_comb begin
      if (extended_layout) begin
         addr.pixel = {display_plane, 1'b0, c, y};
         addr.colour = addr.pixel + BANK_SIZE;
      end else if (!c[5]) begin
         addr.pixel = {3'b000, y[7:4], y[1:0], y[3:2], c[4:0]};
         addr.colour = LEFT_COLOUR_BASE + {5'b00000, y[7:2], c[4:0]};
      end else begin
         addr.pixel = RIGHT_PIXEL_BASE + {5'b00000, y[7:6], y[1:0], y[3:2], y[5:4], c[2:0]};
         addr.colour = LEFT_COLOUR_BASE + RIGHT_COLOUR_OFFSET
                     + {7'b0000000, y[7:6], y[3:2], y[5:4], c[2:0]};
      end
   end
endmodule

### src/ivcf_mem.sv
// Display memory: 64K x 8, one write port and two registered read ports.
// Depends on ivcf_pkg.
module ivcf_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  ivcf_pkg::addr_type       wr_addr,
   input  ivcf_pkg::byte_type       wr_data,
   input  logic                     rd_en,
   input  ivcf_pkg::fetch_addr_type rd_addr,
   output ivcf_pkg::byte_type       pixel_byte,
   output ivcf_pkg::byte_type       colour_byte
);
   import ivcf_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   byte_type mem [DEPTH];
   byte_type pixel_byte_ff;
   byte_type colour_byte_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         pixel_byte_ff <= mem[rd_addr.pixel];
         colour_byte_ff <= mem[rd_addr.colour];
      end
   end

   assign pixel_byte = pixel_byte_ff;
   assign colour_byte = colour_byte_ff;
endmodule

### src/ivcf_expand.sv
// Cell expander: pixel byte and attribute byte to eight palette indices.
// Depends on ivcf_pkg.
module ivcf_expand (
   input  ivcf_pkg::byte_type      pixel_byte,
   input  ivcf_pkg::byte_type      colour_byte,
   input  logic                    blink_active,
   input  ivcf_pkg::byte_type      background_offset,
   output ivcf_pkg::pixel_row_type pixels
);
   import ivcf_pkg::*;

   byte_type bg;
   byte_type fg;

   assign bg = (colour_byte & BG_MASK) + background_offset;

   always_comb begin
      if (blink_active && ((colour_byte & BLINK_MASK) != '0)) begin
         fg = bg;
      end else begin
         fg = (colour_byte >> 3) & FG_MASK;
      end
   end

   always_comb begin
      for (int k = 0; k < PIXELS; k++) begin
         pixels[k] = pixel_byte[PIXELS-1-k] ? fg : bg;
      end
   end
endmodule

### src/interleaved_video_cell_fetch.sv
// Interleaved video cell fetch, top level.
// Render results pass the read and output registers in turn; writes give none.
// Throughput: one word per cycle unless the response receiver holds off ready.
// Reset: synchronous; clears the pipeline valids and restores the layout registers.
// The display memory is not cleared and holds undefined data until written.
// Depends on ivcf_pkg, ivcf_req_if, ivcf_rsp_if, ivcf_addr, ivcf_mem, ivcf_expand.
module interleaved_video_cell_fetch #(
   parameter int BYTE_COLUMNS = ivcf_pkg::DEF_BYTE_COLUMNS,
   parameter int SCAN_LINES = ivcf_pkg::DEF_SCAN_LINES
) (
   input  logic                            clock,
   input  logic                            reset,
   ivcf_req_if.sink                        req_chan,
   ivcf_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [ivcf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ivcf_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ivcf_pkg::*;

   localparam logic [COLUMN_W:0] COLUMN_LIMIT = (COLUMN_W+1)'(BYTE_COLUMNS);
   localparam logic [LINE_W:0] LINE_LIMIT = (LINE_W+1)'(SCAN_LINES);

   logic extended_ff;
   logic plane_ff;
   byte_type bg_offset_ff;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s1_blink_ff;
   logic rsp_valid_ff;
   pixel_row_type pixel_ff;
   pixel_row_type pixel_in;

   logic out_take;
   logic req_ready;
   logic req_fire;
   logic in_range;
   logic render_fire;
   logic write_fire;

   fetch_addr_type fetch_addr;
   byte_type pixel_byte;
   byte_type colour_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         extended_ff <= 1'b0;
         plane_ff <= 1'b0;
         bg_offset_ff <= BG_OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXTENDED_LAYOUT: extended_ff <= csr_write_data[0];
            CSR_DISPLAY_PLANE: plane_ff <= csr_write_data[0];
            CSR_BACKGROUND_OFFSET: bg_offset_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign out_take = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = !s1_valid_ff || out_take;
   assign req_fire = req_chan.valid && req_ready;
   assign in_range = ({1'b0, req_chan.column} < COLUMN_LIMIT)
                  && ({1'b0, req_chan.scan_line} < LINE_LIMIT);
   assign render_fire = req_fire && (req_chan.mode == MODE_RENDER) && in_range;
   assign write_fire = req_fire && (req_chan.mode == MODE_WRITE);
   assign s1_valid_in = render_fire;

   ivcf_addr u_addr (
      .extended_layout (extended_ff),
      .display_plane   (plane_ff),
      .column          (req_chan.column),
      .scan_line       (req_chan.scan_line),
      .addr            (fetch_addr)
   );

   ivcf_mem u_mem (
      .clock       (clock),
      .wr_en       (write_fire),
      .wr_addr     (req_chan.write_address),
      .wr_data     (req_chan.write_data),
      .rd_en       (render_fire),
      .rd_addr     (fetch_addr),
      .pixel_byte  (pixel_byte),
      .colour_byte (colour_byte)
   );

   ivcf_expand u_expand (
      .pixel_byte        (pixel_byte),
      .colour_byte       (colour_byte),
      .blink_active      (s1_blink_ff),
      .background_offset (bg_offset_ff),
      .pixels            (pixel_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (render_fire) begin
         s1_blink_ff <= req_chan.blink_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && s1_valid_ff) begin
         pixel_ff <= pixel_in;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_0 = pixel_ff[0];
   assign rsp_chan.pixel_1 = pixel_ff[1];
   assign rsp_chan.pixel_2 = pixel_ff[2];
   assign rsp_chan.pixel_3 = pixel_ff[3];
   assign rsp_chan.pixel_4 = pixel_ff[4];
   assign rsp_chan.pixel_5 = pixel_ff[5];
   assign rsp_chan.pixel_6 = pixel_ff[6];
   assign rsp_chan.pixel_7 = pixel_ff[7];
endmodule

### tb/tb_interleaved_video_cell_fetch.sv
// Testbench for interleaved_video_cell_fetch: directed cells in both layouts,
// a long receiver hold-off, then random writes and renders under several settings.
// Depends on ivcf_pkg, ivcf_req_if, ivcf_rsp_if and the block itself.
module tb_interleaved_video_cell_fetch;
   import ivcf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 6;
   localparam int MAX_PRINTED = 30;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 170;
   localparam int HOLD_OFF_CYCLES = 90;

   typedef struct {
      logic                mode;
      addr_type            write_address;
      byte_type            write_data;
      logic [COLUMN_W-1:0] column;
      logic [LINE_W-1:0]   scan_line;
      logic                blink_active;
   } cell_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   ivcf_req_if req_chan ();
   ivcf_rsp_if rsp_chan ();

   interleaved_video_cell_fetch uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   byte_type video_ram [0:65535];
   bit byte_written [0:65535];
   logic layout_ext;
   logic plane_sel;
   byte_type bg_offset;
   pixel_row_type cell_rows_due [$];
   int error_count = 0;
   bit req_idle_on = 1'b0;
   bit rsp_stall_on = 1'b0;
   bit hold_off_request = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic fetch_addr_type cell_address(input logic [COLUMN_W-1:0] c,
                                                   input logic [LINE_W-1:0] y);
      fetch_addr_type a;
      addr_type x;
      x = addr_type'(c[2:0]);
      if (layout_ext) begin
         a.pixel = (plane_sel ? 16'h8000 : 16'h0000) + (addr_type'(c) << 8) + addr_type'(y);
         a.colour = a.pixel + BANK_SIZE;
      end else if (c < 32) begin
         a.pixel = addr_type'(c[4:0]) | (addr_type'(y[3:2]) << 5)
                 | (addr_type'(y[1:0]) << 7) | (addr_type'(y[7:4]) << 9);
         a.colour = LEFT_COLOUR_BASE + (addr_type'(c[4:0]) | (addr_type'(y[7:2]) << 5));
      end else begin
         a.pixel = RIGHT_PIXEL_BASE + (x | (addr_type'(y[5:4]) << 3)
                 | (addr_type'(y[3:2]) << 5) | (addr_type'(y[1:0]) << 7)
                 | (addr_type'(y[7:6]) << 9));
         a.colour = LEFT_COLOUR_BASE + RIGHT_COLOUR_OFFSET + (x
                  | (addr_type'(y[5:4]) << 3) | (addr_type'(y[3:2]) << 5)
                  | (addr_type'(y[7:6]) << 7));
      end
      return a;
   endfunction

   function automatic pixel_row_type expand_cell(input byte_type pix, input byte_type colour,
                                                 input logic blink);
      byte_type bg;
      byte_type fg;
      pixel_row_type row;
      bg = (colour & BG_MASK) + bg_offset;
      if (blink && ((colour & BLINK_MASK) != 0))
         fg = bg;
      else
         fg = (colour >> 3) & FG_MASK;
      for (int k = 0; k < PIXELS; k++)
         row[k] = pix[PIXELS-1-k] ? fg : bg;
      return row;
   endfunction

   function automatic cell_word_type random_word();
      cell_word_type w;
      w.mode = 1'($urandom_range(0, 1));
      w.write_address = addr_type'($urandom_range(0, 65535));
      w.write_data = byte_type'($urandom_range(0, 255));
      w.column = COLUMN_W'($urandom_range(0, 63));
      w.scan_line = LINE_W'($urandom_range(0, 255));
      w.blink_active = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic report(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic send_word(input cell_word_type w);
      int gap;
      fetch_addr_type a;
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= w.mode;
      req_chan.write_address <= w.write_address;
      req_chan.write_data <= w.write_data;
      req_chan.column <= w.column;
      req_chan.scan_line <= w.scan_line;
      req_chan.blink_active <= w.blink_active;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      if (w.mode == MODE_WRITE) begin
         video_ram[w.write_address] = w.write_data;
         byte_written[w.write_address] = 1'b1;
      end else if (w.column < DEF_BYTE_COLUMNS) begin
         a = cell_address(w.column, w.scan_line);
         cell_rows_due.push_back(expand_cell(video_ram[a.pixel], video_ram[a.colour],
                                             w.blink_active));
      end
   endtask

   task automatic write_byte(input addr_type addr, input byte_type data);
      cell_word_type w;
      w = random_word();
      w.mode = MODE_WRITE;
      w.write_address = addr;
      w.write_data = data;
      send_word(w);
   endtask

   task automatic render_cell(input int c, input int y, input logic blink);
      cell_word_type w;
      w = random_word();
      w.mode = MODE_RENDER;
      w.column = COLUMN_W'(c);
      w.scan_line = LINE_W'(y);
      w.blink_active = blink;
      send_word(w);
   endtask

   task automatic load_cell(input int c, input int y, input byte_type pix,
                            input byte_type colour);
      fetch_addr_type a;
      a = cell_address(COLUMN_W'(c), LINE_W'(y));
      write_byte(a.pixel, pix);
      write_byte(a.colour, colour);
   endtask

   task automatic fill_cell(input int c, input int y, input bit refresh, output int words);
      fetch_addr_type a;
      a = cell_address(COLUMN_W'(c), LINE_W'(y));
      words = 0;
      if (refresh || !byte_written[a.pixel]) begin
         write_byte(a.pixel, byte_type'($urandom_range(0, 255)));
         words++;
      end
      if (refresh || !byte_written[a.colour]) begin
         write_byte(a.colour, byte_type'($urandom_range(0, 255)));
         words++;
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (cell_rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_EXTENDED_LAYOUT: layout_ext = data[0];
         CSR_DISPLAY_PLANE: plane_sel = data[0];
         CSR_BACKGROUND_OFFSET: bg_offset = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic ext, input logic plane, input byte_type offset);
      settle();
      write_register(CSR_EXTENDED_LAYOUT, {7'd0, ext});
      write_register(CSR_DISPLAY_PLANE, {7'd0, plane});
      write_register(CSR_BACKGROUND_OFFSET, offset);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_directed_cells();
      load_cell(0, 0, 8'hA5, 8'hFF);
      render_cell(0, 0, 1'b0);
      render_cell(0, 0, 1'b1);
      load_cell(31, 255, 8'h00, 8'h07);
      render_cell(31, 255, 1'b1);
      load_cell(32, 0, 8'hFF, 8'h78);
      render_cell(32, 0, 1'b1);
      load_cell(39, 255, 8'h81, 8'h80);
      render_cell(39, 255, 1'b1);
      render_cell(40, 0, 1'b0);
      render_cell(63, 255, 1'b1);
      write_byte(16'hFFFF, 8'hFF);
      set_config(1'b1, 1'b1, 8'd248);
      load_cell(0, 0, 8'h5A, 8'h87);
      render_cell(0, 0, 1'b1);
      load_cell(39, 255, 8'hF0, 8'h3F);
      render_cell(39, 255, 1'b0);
      set_config(1'b1, 1'b0, 8'd0);
      load_cell(39, 0, 8'h0F, 8'hC7);
      render_cell(39, 0, 1'b0);
   endtask

   task automatic test_back_pressure();
      int words;
      for (int k = 0; k < 4; k++)
         fill_cell(k * 9, k * 60, 1'b1, words);
      settle();
      req_idle_on = 1'b0;
      hold_off_request = 1'b1;
      for (int n = 0; n < 40; n++)
         render_cell((n % 4) * 9, (n % 4) * 60, n[0]);
      settle();
   endtask

   task automatic test_random_phases();
      int count;
      int chunk_left;
      int r;
      int c;
      int words;
      logic ext;
      logic plane;
      byte_type offset;
      fetch_addr_type a;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin ext = 1'b0; plane = 1'b0; offset = 8'd0; end
            1: begin ext = 1'b1; plane = 1'b1; offset = 8'd248; end
            2: begin ext = 1'b0; plane = 1'b1; offset = 8'd248; end
            3: begin ext = 1'b1; plane = 1'b0; offset = 8'd0; end
            default: begin
               ext = 1'($urandom_range(0, 1));
               plane = 1'($urandom_range(0, 1));
               offset = byte_type'($urandom_range(0, 248));
            end
         endcase
         set_config(ext, plane, offset);
         count = 0;
         chunk_left = 0;
         while (count < WORDS_PER_PHASE) begin
            if (chunk_left == 0) begin
               chunk_left = 40;
               req_idle_on = ($urandom_range(0, 3) != 0);
               rsp_stall_on = ($urandom_range(0, 3) != 0);
            end
            chunk_left--;
            r = $urandom_range(0, 99);
            if (r < 70) begin
               c = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 39) : $urandom_range(0, 39);
               r = $urandom_range(0, 255);
               fill_cell(c, r, $urandom_range(0, 2) == 0, words);
               render_cell(c, r, 1'($urandom_range(0, 1)));
               count += words + 1;
            end else if (r < 85) begin
               write_byte(addr_type'($urandom_range(0, 65535)),
                          byte_type'($urandom_range(0, 255)));
               count++;
            end else if (r < 93) begin
               render_cell($urandom_range(DEF_BYTE_COLUMNS, 63), $urandom_range(0, 255),
                           1'($urandom_range(0, 1)));
            end else begin
               a = cell_address(COLUMN_W'($urandom_range(0, 39)),
                                LINE_W'($urandom_range(0, 255)));
               write_byte(a.pixel, byte_type'($urandom_range(0, 255)));
               count++;
            end
         end
      end
   endtask

   initial begin
      int stall;
      pixel_row_type got;
      pixel_row_type want;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got[0] = rsp_chan.pixel_0;
            got[1] = rsp_chan.pixel_1;
            got[2] = rsp_chan.pixel_2;
            got[3] = rsp_chan.pixel_3;
            got[4] = rsp_chan.pixel_4;
            got[5] = rsp_chan.pixel_5;
            got[6] = rsp_chan.pixel_6;
            got[7] = rsp_chan.pixel_7;
            if (cell_rows_due.size() == 0) begin
               report("result word with no render pending");
            end else begin
               want = cell_rows_due.pop_front();
               for (int k = 0; k < PIXELS; k++)
                  if (got[k] !== want[k])
                     report($sformatf("pixel_%0d got %0d want %0d", k, got[k], want[k]));
            end
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else if (stall == 0) begin
            stall = pick_gap(rsp_stall_on);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable
             || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
             || (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL interleaved_video_cell_fetch");
      $finish;
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_WRITE;
      req_chan.write_address <= '0;
      req_chan.write_data <= '0;
      req_chan.column <= '0;
      req_chan.scan_line <= '0;
      req_chan.blink_active <= 1'b0;
      layout_ext = 1'b0;
      plane_sel = 1'b0;
      bg_offset = BG_OFFSET_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cells();
      test_back_pressure();
      test_random_phases();
      settle();
      if (error_count == 0)
         $display("PASS interleaved_video_cell_fetch");
      else
         $display("FAIL interleaved_video_cell_fetch");
      $finish;
   end

endmodule
